### rtl/core/spg_pkg.sv
// Shared constants, codes and types of the segment permutation generator.
package spg_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = 8;
    localparam int DRAW_W       = 12;
    localparam int STAT_W       = 2;
    localparam int IDX_W        = 9;
    localparam int DIV_CNT_W    = $clog2(DRAW_W);

    localparam logic [DRAW_W-1:0] DRAW_RESET = DRAW_W'(100);

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NONE      = 2'd1,
        ST_TOO_LARGE = 2'd2
    } t_status;

    typedef enum logic {
        REQ_GENERATE = 1'b0,
        REQ_CHOOSE   = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_STEP,
        S_DIV,
        S_RD_PICK,
        S_RD_I,
        S_WR,
        S_CH_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DRAW_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } t_mod_rsp;

endpackage

### rtl/core/spg_mod.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle.
module spg_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spg_pkg::t_mod_req i_req,
    output spg_pkg::t_mod_rsp o_rsp
);
    import spg_pkg::*;

    logic                 r_run, n_run;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_div, n_div;
    logic [DRAW_W-1:0]    r_dvd, n_dvd;
    logic [CNT_W:0]       trial;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_dvd  = r_dvd;
        trial  = {r_rem, r_dvd[DRAW_W-1]};
        if (i_req.start) begin
            n_run = 1'b1;
            n_cnt = DIV_CNT_W'(DRAW_W - 1);
            n_rem = '0;
            n_div = i_req.divisor;
            n_dvd = i_req.dividend;
        end else if (r_run) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = CNT_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[CNT_W-1:0];
            end
            n_dvd = {r_dvd[DRAW_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_div <= n_div;
        r_dvd <= n_dvd;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

### rtl/core/segment_permutation_generator_top.sv
// Top level: request sequencer, work and permutation stores, draw register.
// Choose: S_CH_OUT, then the strobe. Refused: strobe in the cycle after the transfer.
// Generate of n: each step starts the modulo unit, waits for its 12 bit-serial iterations,
// then does two work-store reads and one write.
// One request at a time; busy stays high until the result strobe. Receiver cannot stall.
// Synchronous active-low reset: no permutation, read index 1, draw 100; stores not cleared.
module segment_permutation_generator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [spg_pkg::CNT_W-1:0]   i_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [spg_pkg::DRAW_W-1:0]  i_cfg_data,
    output logic                        o_done,
    output logic [spg_pkg::CNT_W-1:0]   o_segment_index,
    output logic [spg_pkg::STAT_W-1:0]  o_status
);
    import spg_pkg::*;

    t_state            r_state, n_state;
    logic [DRAW_W-1:0] r_draw;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_pick, n_pick;
    logic [CNT_W-1:0]  r_stored, n_stored;
    logic [IDX_W-1:0]  r_rdidx, n_rdidx;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_seg, n_seg;
    t_status           r_status, n_status;

    logic [CNT_W-1:0]  r_work_mem [MAX_SEGMENTS];
    logic [CNT_W-1:0]  r_perm_mem [MAX_SEGMENTS];
    logic [CNT_W-1:0]  r_work_q, r_perm_q;

    logic              work_we, perm_we;
    logic [ADDR_W-1:0] work_waddr, work_raddr, perm_waddr, perm_raddr;
    logic [CNT_W-1:0]  work_wdata, perm_wdata;
    logic              too_large;

    t_mod_req          mod_req;
    t_mod_rsp          mod_rsp;

    spg_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign too_large  = (32'(i_count) > 32'(MAX_SEGMENTS - 1));
    assign perm_raddr = ADDR_W'(r_rdidx);

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_k      = r_k;
        n_i      = r_i;
        n_pick   = r_pick;
        n_stored = r_stored;
        n_rdidx  = r_rdidx;
        n_done   = 1'b0;
        n_seg    = r_seg;
        n_status = r_status;

        mod_req.start    = 1'b0;
        mod_req.dividend = r_draw;
        mod_req.divisor  = r_n - r_i + 1'b1;

        work_we    = 1'b0;
        work_waddr = ADDR_W'(r_k);
        work_wdata = r_k;
        work_raddr = ADDR_W'(r_pick);
        perm_we    = 1'b0;
        perm_waddr = ADDR_W'(r_i);
        perm_wdata = r_work_q;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req_type == REQ_GENERATE) begin
                        if (too_large) begin
                            n_done   = 1'b1;
                            n_seg    = '0;
                            n_status = ST_TOO_LARGE;
                        end else begin
                            n_n     = i_count;
                            n_k     = '0;
                            n_state = S_FILL;
                        end
                    end else begin
                        if (r_stored == '0 || r_rdidx > {1'b0, r_stored}) begin
                            n_done   = 1'b1;
                            n_seg    = '0;
                            n_status = ST_NONE;
                        end else begin
                            n_state = S_CH_OUT;
                        end
                    end
                end
            end
            S_FILL: begin
                work_we = 1'b1;
                if (r_k == r_n) begin
                    n_i = CNT_W'(1);
                    if (r_n == '0) begin
                        n_stored = r_n;
                        n_rdidx  = IDX_W'(1);
                        n_done   = 1'b1;
                        n_seg    = '0;
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_STEP;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_STEP: begin
                mod_req.start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (mod_rsp.done) begin
                    n_pick  = r_i + mod_rsp.remainder;
                    n_state = S_RD_PICK;
                end
            end
            S_RD_PICK: begin
                n_state = S_RD_I;
            end
            S_RD_I: begin
                work_raddr = ADDR_W'(r_i);
                perm_we    = 1'b1;
                n_state    = S_WR;
            end
            S_WR: begin
                work_we    = 1'b1;
                work_waddr = ADDR_W'(r_pick);
                work_wdata = r_work_q;
                if (r_i == r_n) begin
                    n_stored = r_n;
                    n_rdidx  = IDX_W'(1);
                    n_done   = 1'b1;
                    n_seg    = '0;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_STEP;
                end
            end
            S_CH_OUT: begin
                n_seg    = r_perm_q;
                n_status = ST_OK;
                n_done   = 1'b1;
                n_rdidx  = r_rdidx + 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stored <= '0;
            r_rdidx  <= IDX_W'(1);
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stored <= n_stored;
            r_rdidx  <= n_rdidx;
            r_done   <= n_done;
        end
        r_n      <= n_n;
        r_k      <= n_k;
        r_i      <= n_i;
        r_pick   <= n_pick;
        r_seg    <= n_seg;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw <= DRAW_RESET;
        end else if (i_cfg_valid) begin
            r_draw <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work_mem[work_waddr] <= work_wdata;
        end
        r_work_q <= r_work_mem[work_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm_mem[perm_waddr] <= perm_wdata;
        end
        r_perm_q <= r_perm_mem[perm_raddr];
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_done          = r_done;
    assign o_segment_index = r_seg;
    assign o_status        = r_status;

endmodule

### rtl/core/spg_checker.sv
// Port-level checker for the segment permutation generator, bound to the top level.
module spg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [spg_pkg::CNT_W-1:0]   o_segment_index,
    input logic [spg_pkg::STAT_W-1:0]  o_status
);
    import spg_pkg::*;

    a_transfer_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("request transfer neither started work nor answered");

    a_no_busy_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result strobe without a request");

    a_fail_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_segment_index == '0))
        else $error("failed request carries a segment index");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_NONE || o_status == ST_TOO_LARGE))
        else $error("undefined status code");

endmodule

bind segment_permutation_generator_top spg_checker u_spg_checker (.*);
